// ===== rtl/core/rmst_pkg.sv =====
// Package for the range-max segment tree core: sizes, sequencer states and
// the structs passed between the sequencer, node RAM and top level.
// No dependencies.
package rmst_pkg;

  localparam int LEAVES     = 1024;
  localparam int NODE_COUNT = 2 * LEAVES;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int PTR_W      = NODE_W + 1;
  localparam int IDX_W      = 10;
  localparam int VAL_W      = 31;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_UP,
    ST_Q_LO,
    ST_Q_LO_DATA,
    ST_Q_HI_DATA,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] index_low;
    logic [IDX_W-1:0] index_high;
    logic [VAL_W-1:0] new_value;
  } cmd_t;

  typedef struct packed {
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] data;
  } res_t;

endpackage

// ===== rtl/core/rmst_max_unit.sv =====
// Shared compare-and-select unit: larger of two node values.
// Depends on rmst_pkg.
module rmst_max_unit (
  input  logic [rmst_pkg::VAL_W-1:0] a,
  input  logic [rmst_pkg::VAL_W-1:0] b,
  output logic [rmst_pkg::VAL_W-1:0] y
);
  import rmst_pkg::*;

  assign y = (a > b) ? a : b;

endmodule

// ===== rtl/core/rmst_node_ram.sv =====
// Node store of the segment tree: one write port, one read port with
// registered read data. Depends on rmst_pkg.
module rmst_node_ram (
  input  logic                       clk,
  input  rmst_pkg::ram_req_t         req,
  output logic [rmst_pkg::VAL_W-1:0] rd_data
);
  import rmst_pkg::*;

  logic [VAL_W-1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/core/rmst_seq.sv =====
// Sequencer of the segment tree: clearing sweep, leaf raise with ancestor
// walk, and range-max walk, all via the node RAM; the walks share one max unit.
// Depends on rmst_pkg and rmst_max_unit.
module rmst_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  rmst_pkg::cmd_t             cmd,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  output rmst_pkg::ram_req_t         ram,
  input  logic [rmst_pkg::VAL_W-1:0] rd_data,
  output rmst_pkg::res_t             res,
  input  logic                       res_ready
);
  import rmst_pkg::*;

  state_t            state, state_next;
  logic [NODE_W-1:0] k, k_next;
  logic [NODE_W-1:0] clr_cnt, clr_cnt_next;
  logic [PTR_W-1:0]  lo, lo_next;
  logic [PTR_W-1:0]  hi, hi_next;
  logic [VAL_W-1:0]  acc, acc_next;
  logic [VAL_W-1:0]  max_y;
  logic [PTR_W-1:0]  lo_adv;
  logic [IDX_W-1:0]  hi_sat;
  logic              q_empty;
  logic [NODE_W-1:0] parent;

  rmst_max_unit u_max (
    .a(acc),
    .b(rd_data),
    .y(max_y)
  );

  assign lo_adv  = (state == ST_Q_LO_DATA) ? lo + PTR_W'(1) : lo;
  assign hi_sat  = (cmd.index_high >= LEAVES) ? IDX_W'(LEAVES - 1) : cmd.index_high;
  assign q_empty = (cmd.index_low >= LEAVES) || (cmd.index_low > hi_sat);
  assign parent  = k >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    k   <= k_next;
    lo  <= lo_next;
    hi  <= hi_next;
    acc <= acc_next;
  end

  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    k_next       = k;
    lo_next      = lo;
    hi_next      = hi;
    acc_next     = acc;
    ram          = '0;
    cmd_ready    = 1'b0;
    res          = '0;
    case (state)
      ST_CLEAR: begin
        ram.wr_en    = 1'b1;
        ram.wr_addr  = clr_cnt;
        ram.wr_data  = '0;
        clr_cnt_next = clr_cnt + NODE_W'(1);
        if (clr_cnt == NODE_W'(NODE_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.kind == KIND_UPDATE) begin
            acc_next = cmd.new_value;
            k_next   = NODE_W'(LEAVES) + NODE_W'(cmd.index_low);
            // drop updates aimed past the last leaf
            if (cmd.index_low < LEAVES) begin
              ram.rd_en   = 1'b1;
              ram.rd_addr = NODE_W'(LEAVES) + NODE_W'(cmd.index_low);
              state_next  = ST_UPD_LEAF;
            end
          end else begin
            acc_next = '0;
            lo_next  = PTR_W'(LEAVES) + PTR_W'(cmd.index_low);
            hi_next  = PTR_W'(LEAVES) + PTR_W'(hi_sat);
            state_next = q_empty ? ST_Q_DONE : ST_Q_LO;
          end
        end
      end
      ST_UPD_LEAF: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = k;
        ram.wr_data = max_y;
        acc_next    = max_y;
        ram.rd_en   = 1'b1;
        ram.rd_addr = k ^ NODE_W'(1);
        state_next  = ST_UPD_UP;
      end
      ST_UPD_UP: begin
        // read data: sibling of k; write parent, fetch its sibling unless root
        ram.wr_en   = 1'b1;
        ram.wr_addr = parent;
        ram.wr_data = max_y;
        acc_next    = max_y;
        k_next      = parent;
        if (parent == NODE_W'(1)) begin
          state_next = ST_IDLE;
        end else begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = parent ^ NODE_W'(1);
        end
      end
      ST_Q_LO: begin
        if (lo > hi) begin
          state_next = ST_Q_DONE;
        end else if (lo[0]) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = lo[NODE_W-1:0];
          state_next  = ST_Q_LO_DATA;
        end else if (!hi[0]) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = hi[NODE_W-1:0];
          state_next  = ST_Q_HI_DATA;
        end else begin
          lo_next    = lo_adv >> 1;
          hi_next    = hi >> 1;
          state_next = ST_Q_LO;
        end
      end
      ST_Q_LO_DATA: begin
        acc_next = max_y;
        if (!hi[0]) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = hi[NODE_W-1:0];
          lo_next     = lo_adv;
          state_next  = ST_Q_HI_DATA;
        end else begin
          lo_next    = lo_adv >> 1;
          hi_next    = hi >> 1;
          state_next = ST_Q_LO;
        end
      end
      ST_Q_HI_DATA: begin
        acc_next   = max_y;
        lo_next    = lo >> 1;
        hi_next    = (hi - PTR_W'(1)) >> 1;
        state_next = ST_Q_LO;
      end
      ST_Q_DONE: begin
        // hold the result until the output register can take it
        res.valid = 1'b1;
        res.data  = acc;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_root_zero_write: assert property (@(posedge clk) disable iff (rst)
    (ram.wr_en && state != ST_CLEAR) |-> (ram.wr_addr != '0))
    else $error("node 0 written outside the clearing sweep");

  a_walk_below_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD_UP) |-> (k >= NODE_W'(2)))
    else $error("ancestor walk continued past the root");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_ready) |=> (res.valid && $stable(res.data)))
    else $error("query result dropped or changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> (state == ST_IDLE && !ram.wr_en))
    else $error("command taken while the tree walk is busy");
`endif

endmodule

// ===== rtl/core/range_max_segment_tree_core.sv =====
// Top level of the range-max segment tree core: stream ports, output
// register, node RAM and sequencer. Depends on rmst_pkg, rmst_node_ram, rmst_seq.
//
//  channel   dir  fields (low bit up)                                 role
//  s_*       in   tuser: kind; tdata: index_low, index_high, new_value update / query
//  m_*       out  tdata: range_max                                    one per query
//
// Update: one tree level per cycle, set by the single read and single write
// port of the node RAM. Query: up to two node reads per level through the one
// read port. After reset a clearing sweep writes all 2*LEAVES nodes before
// s_tready rises. A stalled m_* holds one result; the next item is taken
// meanwhile, and a second query result waits inside until the register frees.
module range_max_segment_tree_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [9:0] index_low, [19:10] index_high, [50:20] new_value
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [30:0] range_max
);
  import rmst_pkg::*;

  cmd_t             cmd;
  ram_req_t         ram_req;
  logic [VAL_W-1:0] rd_data;
  res_t             res;
  logic             slot_free;
  logic [VAL_W-1:0] range_max;

  assign cmd.kind       = s_tuser;
  assign cmd.index_low  = s_tdata[9:0];
  assign cmd.index_high = s_tdata[19:10];
  assign cmd.new_value  = s_tdata[50:20];

  assign slot_free = !m_tvalid || m_tready;

  rmst_node_ram u_ram (
    .clk    (clk),
    .req    (ram_req),
    .rd_data(rd_data)
  );

  rmst_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_valid(s_tvalid),
    .cmd_ready(s_tready),
    .ram      (ram_req),
    .rd_data  (rd_data),
    .res      (res),
    .res_ready(slot_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && slot_free) begin
      range_max <= res.data;
    end
  end

  assign m_tdata = {1'b0, range_max};

endmodule
